### rtl/ctmw_pkg.sv
// Shared types and constants for the card information tuple walker.
// No dependencies; every other file in rtl/ imports this package.
package ctmw_pkg;

  // Address and field widths
  localparam int unsigned ADDR_W         = 17;
  localparam int unsigned MAX_TUPLES_DEF = 128;

  // Tuple codes and limits
  localparam logic [7:0] CODE_END        = 8'hFF;
  localparam logic [7:0] CODE_MANFID     = 8'h20;
  localparam logic [7:0] MANFID_MIN_LINK = 8'd4;

  // Input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Read status of a delivered byte
  localparam logic [1:0] RS_OK      = 2'd0;
  localparam logic [1:0] RS_TIMEOUT = 2'd1;

  // Result kinds
  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;

  // Final walk status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_CIS = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_CRC     = 2'd3;

  // One input beat
  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic [1:0] read_status;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic [1:0]        result_kind;
    logic [ADDR_W-1:0] read_address;
    logic [1:0]        status;
    logic [15:0]       manufacturer_id;
    logic [15:0]       card_id;
  } result_t;

endpackage

### rtl/ctmw_ifs.sv
// Channel interfaces for the tuple walker: input, result and config write.
// Depends on ctmw_pkg for the address width.

interface ctmw_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  logic [1:0] read_status;

  modport source (output valid, output opcode, output data_byte,
                  output read_status, input ready);
  modport sink (input valid, input opcode, input data_byte,
                input read_status, output ready);
endinterface

interface ctmw_out_if;
  import ctmw_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [ADDR_W-1:0] read_address;
  logic [1:0]        status;
  logic [15:0]       manufacturer_id;
  logic [15:0]       card_id;

  modport source (output valid, output result_kind, output read_address,
                  output status, output manufacturer_id, output card_id,
                  input ready);
  modport sink (input valid, input result_kind, input read_address,
                input status, input manufacturer_id, input card_id,
                output ready);
endinterface

interface ctmw_cfg_if;
  import ctmw_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/ctmw_walk_core.sv
// Walk state and next-step logic: one accepted beat in, one result out.
// Depends on ctmw_pkg for beat/result types and tuple constants.
module ctmw_walk_core #(
  parameter int unsigned MAX_TUPLES = ctmw_pkg::MAX_TUPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  ctmw_pkg::in_beat_t            beat,
  input  logic [ctmw_pkg::ADDR_W-1:0]   cis_start,
  output ctmw_pkg::result_t             res
);
  import ctmw_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TUPLES + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CODE,
    PH_LINK,
    PH_BODY
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [ADDR_W-1:0] tuple_r, tuple_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [23:0]       id_r, id_nxt;

  logic [CNT_W-1:0]  seen_inc;
  logic [1:0]        idx_inc;

  assign seen_inc = seen_r + CNT_W'(1);
  assign idx_inc  = idx_r + 2'd1;

  // Next state and result for the beat on hand
  always_comb begin
    phase_nxt = phase_r;
    tuple_nxt = tuple_r;
    seen_nxt  = seen_r;
    idx_nxt   = idx_r;
    id_nxt    = id_r;
    res       = '0;

    if (beat.opcode == OP_START) begin
      if (cis_start == '0) begin
        phase_nxt       = PH_IDLE;
        res.result_kind = KIND_DONE;
        res.status      = ST_BAD_CIS;
      end else begin
        tuple_nxt        = cis_start;
        seen_nxt         = '0;
        idx_nxt          = 2'd0;
        id_nxt           = '0;
        phase_nxt        = PH_CODE;
        res.result_kind  = KIND_READ;
        res.read_address = cis_start;
      end
    end else if (phase_r == PH_IDLE) begin
      res.result_kind = KIND_IGNORED;
    end else if (beat.read_status != RS_OK) begin
      // failed read: timeout, anything else counts as crc
      phase_nxt       = PH_IDLE;
      res.result_kind = KIND_DONE;
      res.status      = (beat.read_status == RS_TIMEOUT) ? ST_TIMEOUT : ST_CRC;
    end else begin
      case (phase_r)
        PH_CODE: begin
          if (beat.data_byte == CODE_END) begin
            phase_nxt       = PH_IDLE;
            res.result_kind = KIND_DONE;
            res.status      = ST_BAD_CIS;
          end else begin
            id_nxt           = {16'd0, beat.data_byte};
            phase_nxt        = PH_LINK;
            res.result_kind  = KIND_READ;
            res.read_address = tuple_r + ADDR_W'(1);
          end
        end
        PH_LINK: begin
          if (id_r == {16'd0, CODE_MANFID}) begin
            if (beat.data_byte < MANFID_MIN_LINK) begin
              phase_nxt       = PH_IDLE;
              res.result_kind = KIND_DONE;
              res.status      = ST_BAD_CIS;
            end else begin
              id_nxt           = '0;
              idx_nxt          = 2'd0;
              phase_nxt        = PH_BODY;
              res.result_kind  = KIND_READ;
              res.read_address = tuple_r + ADDR_W'(2);
            end
          end else begin
            // skip this tuple: code, link and body
            tuple_nxt = tuple_r + ADDR_W'(2) + ADDR_W'(beat.data_byte);
            seen_nxt  = seen_inc;
            if (seen_inc >= CNT_W'(MAX_TUPLES)) begin
              phase_nxt       = PH_IDLE;
              res.result_kind = KIND_DONE;
              res.status      = ST_BAD_CIS;
            end else begin
              phase_nxt        = PH_CODE;
              res.result_kind  = KIND_READ;
              res.read_address = tuple_nxt;
            end
          end
        end
        PH_BODY: begin
          if (idx_r != 2'd3) begin
            case (idx_r)
              2'd0:    id_nxt[7:0]   = id_r[7:0]   | beat.data_byte;
              2'd1:    id_nxt[15:8]  = id_r[15:8]  | beat.data_byte;
              default: id_nxt[23:16] = id_r[23:16] | beat.data_byte;
            endcase
            idx_nxt          = idx_inc;
            res.result_kind  = KIND_READ;
            res.read_address = tuple_r + ADDR_W'(2) + ADDR_W'(idx_inc);
          end else begin
            phase_nxt           = PH_IDLE;
            res.result_kind     = KIND_DONE;
            res.status          = ST_OK;
            res.manufacturer_id = id_r[15:0];
            res.card_id         = {beat.data_byte, id_r[23:16]};
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // State registers, advanced once per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tuple_r <= '0;
      seen_r  <= '0;
      idx_r   <= 2'd0;
      id_r    <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      tuple_r <= tuple_nxt;
      seen_r  <= seen_nxt;
      idx_r   <= idx_nxt;
      id_r    <= id_nxt;
    end
  end

endmodule

### rtl/ctmw_out_stage.sv
// Result register with valid flag, holding a beat until the sink takes it.
// Depends on ctmw_pkg for the result type.
module ctmw_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ctmw_pkg::result_t res_in,
  input  logic              take,
  output logic              valid,
  output ctmw_pkg::result_t res_q
);
  import ctmw_pkg::*;

  logic    valid_r;
  result_t res_r;

  // Valid flag: set on load, cleared once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid = valid_r;
  assign res_q = res_r;

endmodule

### rtl/cis_tuple_manufacturer_walk.sv
// Card information tuple walker: finds the manufacturer-ID tuple.
// An accepted input beat's result beat is registered and valid in the next cycle.
// Throughput: one beat per cycle; the next-step logic sits between the walk
// state and the result register, and input is taken whenever that register
// is empty or being emptied. Synchronous active-low reset clears the walk to
// idle, cis_start to zero and the result register to empty.
module cis_tuple_manufacturer_walk #(
  parameter int unsigned MAX_TUPLES = ctmw_pkg::MAX_TUPLES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ctmw_in_if.sink    in_if,
  ctmw_out_if.source out_if,
  ctmw_cfg_if.sink   cfg_if
);
  import ctmw_pkg::*;

  logic              in_fire;
  logic              out_valid;
  logic [ADDR_W-1:0] cis_start_r;
  in_beat_t          beat;
  result_t           step_res;
  result_t           res_q;

  // Configuration register
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cis_start_r <= '0;
    end else if (cfg_if.valid) begin
      cis_start_r <= cfg_if.data;
    end
  end

  // Input handshake
  assign in_if.ready = !out_valid || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  assign beat.opcode      = in_if.opcode;
  assign beat.data_byte   = in_if.data_byte;
  assign beat.read_status = in_if.read_status;

  ctmw_walk_core #(
    .MAX_TUPLES (MAX_TUPLES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_fire),
    .beat      (beat),
    .cis_start (cis_start_r),
    .res       (step_res)
  );

  ctmw_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_fire),
    .res_in (step_res),
    .take   (out_if.ready),
    .valid  (out_valid),
    .res_q  (res_q)
  );

  // Result channel
  assign out_if.valid           = out_valid;
  assign out_if.result_kind     = res_q.result_kind;
  assign out_if.read_address    = res_q.read_address;
  assign out_if.status          = res_q.status;
  assign out_if.manufacturer_id = res_q.manufacturer_id;
  assign out_if.card_id         = res_q.card_id;

  // Every accepted beat shows a result in the next cycle
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_if.valid)
    else $error("accepted beat produced no result");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (out_if.valid && !out_if.ready))
    else $error("input stalled without a waiting result");

  // Only read requests carry an address
  a_addr_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.result_kind != KIND_READ) |-> out_if.read_address == '0)
    else $error("address on a non-read result");

  // IDs appear only on a successful finish
  a_ids_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.result_kind != KIND_DONE || out_if.status != ST_OK))
      |-> (out_if.manufacturer_id == '0 && out_if.card_id == '0))
    else $error("IDs on a result that is not a successful finish");

endmodule

### tb/ctmw_walk_checker.sv
// Scoreboard for the tuple walker. It watches the input, result and config
// channels, predicts every result beat and compares it field by field.
// Depends on ctmw_pkg and the channel interfaces in rtl/ctmw_ifs.sv.
module ctmw_walk_checker #(
  parameter int unsigned MAX_TUPLES = ctmw_pkg::MAX_TUPLES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ctmw_in_if   in_ch,
  ctmw_out_if  out_ch,
  ctmw_cfg_if  cfg_ch,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ctmw_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_CODE, PH_LINK, PH_BODY} walk_phase_t;

  // Predicted walk state
  walk_phase_t       phase;
  logic [ADDR_W-1:0] chain_start;
  logic [ADDR_W-1:0] tuple_addr;
  logic [7:0]        skipped;
  logic [1:0]        body_idx;
  logic [23:0]       gathered;

  // Result beats predicted but not yet seen on the output
  result_t awaited_results[$];

  function automatic result_t walk_done(logic [1:0] st, logic [15:0] man,
                                        logic [15:0] card);
    result_t r;
    r = '0;
    phase = PH_IDLE;
    r.result_kind     = KIND_DONE;
    r.status          = st;
    r.manufacturer_id = man;
    r.card_id         = card;
    return r;
  endfunction

  // Advance the walk by one input beat and return the result it produces
  function automatic result_t walk_step(in_beat_t beat);
    result_t r;
    r = '0;
    if (beat.opcode == OP_START) begin
      if (chain_start == '0) return walk_done(ST_BAD_CIS, 16'h0, 16'h0);
      tuple_addr = chain_start;
      skipped    = '0;
      body_idx   = '0;
      gathered   = '0;
      phase      = PH_CODE;
      r.result_kind  = KIND_READ;
      r.read_address = tuple_addr;
      return r;
    end
    if (phase == PH_IDLE) begin
      r.result_kind = KIND_IGNORED;
      return r;
    end
    if (beat.read_status != RS_OK)
      return walk_done(beat.read_status == RS_TIMEOUT ? ST_TIMEOUT : ST_CRC,
                       16'h0, 16'h0);
    r.result_kind = KIND_READ;
    case (phase)
      PH_CODE: begin
        if (beat.data_byte == CODE_END) return walk_done(ST_BAD_CIS, 16'h0, 16'h0);
        // code byte is held until its link arrives
        gathered = 24'(beat.data_byte);
        phase = PH_LINK;
        r.read_address = tuple_addr + ADDR_W'(1);
      end
      PH_LINK: begin
        if (gathered == 24'(CODE_MANFID)) begin
          if (beat.data_byte < MANFID_MIN_LINK)
            return walk_done(ST_BAD_CIS, 16'h0, 16'h0);
          gathered = '0;
          body_idx = '0;
          phase = PH_BODY;
          r.read_address = tuple_addr + ADDR_W'(2);
        end else begin
          // hop over this tuple, address wraps at the field width
          tuple_addr = tuple_addr + ADDR_W'(2) + ADDR_W'(beat.data_byte);
          skipped = skipped + 8'd1;
          if (skipped >= MAX_TUPLES) return walk_done(ST_BAD_CIS, 16'h0, 16'h0);
          phase = PH_CODE;
          r.read_address = tuple_addr;
        end
      end
      default: begin
        if (body_idx == 2'd3)
          return walk_done(ST_OK, gathered[15:0], {beat.data_byte, gathered[23:16]});
        gathered = gathered | (24'(beat.data_byte) << (8 * body_idx));
        body_idx = body_idx + 2'd1;
        r.read_address = tuple_addr + ADDR_W'(2) + ADDR_W'(body_idx);
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Sample all three channels at the rising edge
  always @(posedge clk) begin
    result_t  got;
    result_t  want;
    in_beat_t beat;
    if (!rst_n) begin
      phase       = PH_IDLE;
      chain_start = '0;
      tuple_addr  = '0;
      skipped     = '0;
      body_idx    = '0;
      gathered    = '0;
      mismatches  = 0;
      awaited_results.delete();
    end else begin
      // results first: a beat accepted at this edge cannot answer yet
      if (out_ch.valid && out_ch.ready) begin
        got.result_kind     = out_ch.result_kind;
        got.read_address    = out_ch.read_address;
        got.status          = out_ch.status;
        got.manufacturer_id = out_ch.manufacturer_id;
        got.card_id         = out_ch.card_id;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result beat expected none got %h", $time, got);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind", want.result_kind, got.result_kind);
          check_field("read_address", want.read_address, got.read_address);
          check_field("status", want.status, got.status);
          check_field("manufacturer_id", want.manufacturer_id, got.manufacturer_id);
          check_field("card_id", want.card_id, got.card_id);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) chain_start = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        beat.opcode      = in_ch.opcode;
        beat.data_byte   = in_ch.data_byte;
        beat.read_status = in_ch.read_status;
        awaited_results.push_back(walk_step(beat));
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

### tb/testbench.sv
// Top of the tuple walker testbench: clock, reset, stimulus and verdict.
// Depends on ctmw_pkg, rtl/ctmw_ifs.sv, the walker RTL and ctmw_walk_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ctmw_pkg::*;

  localparam int         CYCLE_LIMIT = 600000;
  localparam int         HOLD_CYCLES = 160;
  localparam logic [1:0] RS_CRC      = 2'd2;
  localparam logic [1:0] RS_SPARE    = 2'd3;

  typedef enum {TAIL_MANFID, TAIL_SHORT_LINK, TAIL_CHAIN_END, TAIL_CUT, TAIL_NOISE}
    chain_tail_t;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   cycle_count;

  // Idle modes: 0 none, 1 uniform 0..18, 2 mostly none with odd long gaps
  int   in_mode;
  int   out_mode;
  bit   hold_off_req;
  int   beats_sent;

  // Bookkeeping for injecting a failed read part way through a chain
  int   chain_pos;
  int   chain_fail_at;
  bit   chain_dead;

  ctmw_in_if  in_ch();
  ctmw_out_if out_ch();
  ctmw_cfg_if cfg_ch();

  cis_tuple_manufacturer_walk u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  ctmw_walk_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic int draw_gap(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 18);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
  endfunction

  // Any code byte other than the manfid and end-of-chain codes
  function automatic logic [7:0] plain_code();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CODE_MANFID || c == CODE_END);
    return c;
  endfunction

  // Result side: random stalls per beat, plus one long hold-off on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(negedge clk iff rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = draw_gap(out_mode);
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  task automatic send_beat(logic op, logic [7:0] data, logic [1:0] rs);
    int gap;
    gap = draw_gap(in_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.data_byte   <= data;
    in_ch.read_status <= rs;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_start(logic [ADDR_W-1:0] addr);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= addr;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // One byte of a well-formed chain, or the failed read that cuts it off
  task automatic chain_byte(logic [7:0] value);
    if (chain_dead) return;
    if (chain_pos == chain_fail_at) begin
      send_beat(OP_BYTE, 8'($urandom), 2'($urandom_range(RS_TIMEOUT, RS_SPARE)));
      chain_dead = 1'b1;
    end else begin
      send_beat(OP_BYTE, value, RS_OK);
    end
    chain_pos++;
  endtask

  // A start, n_skip tuples to hop over, then the chosen tail
  task automatic send_chain(int n_skip, chain_tail_t tail, int fail_at);
    chain_pos     = 0;
    chain_fail_at = fail_at;
    chain_dead    = 1'b0;
    // a start ignores its byte and status, so both get random values
    send_beat(OP_START, 8'($urandom), 2'($urandom_range(0, 3)));
    for (int i = 0; i < n_skip; i++) begin
      chain_byte(plain_code());
      chain_byte(8'($urandom));
    end
    case (tail)
      TAIL_MANFID: begin
        chain_byte(CODE_MANFID);
        chain_byte(8'($urandom_range(MANFID_MIN_LINK, 255)));
        repeat (4) chain_byte(8'($urandom));
      end
      TAIL_SHORT_LINK: begin
        chain_byte(CODE_MANFID);
        chain_byte(8'($urandom_range(0, MANFID_MIN_LINK - 1)));
      end
      TAIL_CHAIN_END: chain_byte(CODE_END);
      TAIL_CUT: begin
        // left mid-walk; the next start takes over
        chain_byte(CODE_MANFID);
        repeat ($urandom_range(0, 3)) chain_byte(8'($urandom));
      end
      default: begin
        repeat ($urandom_range(1, 5))
          send_beat(1'($urandom), 8'($urandom), 2'($urandom_range(0, 3)));
      end
    endcase
  endtask

  task automatic random_walk();
    int          n_skip;
    int          pick;
    int          fail_at;
    chain_tail_t tail;
    n_skip = ($urandom_range(0, 79) == 0) ? $urandom_range(120, 130)
                                          : $urandom_range(0, 5);
    pick = $urandom_range(0, 99);
    if (pick < 45)      tail = TAIL_MANFID;
    else if (pick < 55) tail = TAIL_SHORT_LINK;
    else if (pick < 70) tail = TAIL_CHAIN_END;
    else if (pick < 80) tail = TAIL_CUT;
    else                tail = TAIL_NOISE;
    fail_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 2 * n_skip + 5) : -1;
    send_chain(n_skip, tail, fail_at);
  endtask

  // Stimulus and verdict
  initial begin
    logic [ADDR_W-1:0] addr;
    int                goal;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_START;
    in_ch.data_byte    = 8'h00;
    in_ch.read_status  = RS_OK;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    hold_off_req       = 1'b0;
    beats_sent         = 0;
    in_mode            = 1;
    out_mode           = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: no chain, then a byte while idle
    write_start('0);
    send_beat(OP_START, 8'hFF, RS_SPARE);
    send_beat(OP_BYTE, 8'hFF, RS_OK);

    // Directed: top address so the walk wraps past the end of the address space
    write_start('1);
    send_beat(OP_START, 8'h00, RS_OK);
    send_beat(OP_BYTE, 8'h00, RS_OK);
    send_beat(OP_BYTE, 8'hFF, RS_OK);
    send_beat(OP_BYTE, CODE_MANFID, RS_OK);
    send_beat(OP_BYTE, MANFID_MIN_LINK, RS_OK);
    send_beat(OP_BYTE, 8'hFF, RS_OK);
    send_beat(OP_BYTE, 8'h00, RS_OK);
    send_beat(OP_BYTE, 8'hAA, RS_OK);
    send_beat(OP_BYTE, 8'h55, RS_OK);
    // end-of-chain code
    send_beat(OP_START, 8'h00, RS_OK);
    send_beat(OP_BYTE, CODE_END, RS_OK);
    // manfid link too short
    send_beat(OP_START, 8'h00, RS_OK);
    send_beat(OP_BYTE, CODE_MANFID, RS_OK);
    send_beat(OP_BYTE, MANFID_MIN_LINK - 8'd1, RS_OK);
    // failed reads: timeout, crc, and the spare status
    send_beat(OP_START, 8'h00, RS_OK);
    send_beat(OP_BYTE, 8'h00, RS_TIMEOUT);
    send_beat(OP_START, 8'h00, RS_OK);
    send_beat(OP_BYTE, CODE_MANFID, RS_OK);
    send_beat(OP_BYTE, 8'hFF, RS_CRC);
    send_beat(OP_START, 8'h00, RS_OK);
    send_beat(OP_BYTE, 8'h00, RS_SPARE);
    // restart part way through a walk
    send_beat(OP_START, 8'h00, RS_OK);
    send_beat(OP_START, 8'hFF, RS_OK);

    // Random phases, each with its own chain start and idle pattern
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       addr = ADDR_W'(1);
        2:       addr = '0;
        3:       addr = '1;
        6:       addr = ADDR_W'(17'h1FFF0);
        default: addr = ADDR_W'($urandom_range(1, 17'h1FFFF));
      endcase
      write_start(addr);
      in_mode  = p % 3;
      out_mode = (p + 2) % 3;
      if (p == 4) begin
        // sender keeps pushing while the receiver sits on its ready
        in_mode      = 0;
        hold_off_req = 1'b1;
      end
      goal = beats_sent + ((p == 2) ? 40 : 60);
      if (p == 5) send_chain(MAX_TUPLES_DEF, TAIL_MANFID, -1);
      if (p == 6) send_chain(MAX_TUPLES_DEF - 1, TAIL_MANFID, -1);
      while (beats_sent < goal) random_walk();
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
